[rtl/mrld_pkg.sv]
// Package: shared types and constants of the marker run-length decoder.
package mrld_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int REPEAT_W        = 32;
	localparam int STATUS_W        = 3;

	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NONDIGIT     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNTERMINATED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW     = 3'd4;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ONE   = 8'h31;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} src_t;

	typedef struct packed {
		logic [7:0]          out_byte;
		logic [REPEAT_W-1:0] repeat_count;
		logic [STATUS_W-1:0] status;
		logic                done_res;
	} res_t;

	typedef struct packed {
		logic in_run;
		logic run_is_ones;
		logic seen_digit;
		logic stopped;
	} flags_t;

endpackage

[rtl/mrld_step.sv]
// Next-state and result logic for one stream byte.
module mrld_step #(
	parameter int COUNT_WIDTH = mrld_pkg::COUNT_WIDTH_DEF
) (
	input  mrld_pkg::src_t           src,
	input  mrld_pkg::flags_t         flags,
	input  logic [COUNT_WIDTH-1:0]   count,
	output mrld_pkg::flags_t         flags_nxt,
	output logic [COUNT_WIDTH-1:0]   count_nxt,
	output logic                     emit,
	output mrld_pkg::res_t           res
);

	logic [7:0]                        b;
	logic [7:0]                        marker;
	logic [COUNT_WIDTH+3:0]            prod;
	logic                              ovf;
	logic [COUNT_WIDTH+mrld_pkg::REPEAT_W-1:0] cnt_ext;

	assign b       = src.in_byte;
	assign marker  = flags.run_is_ones ? mrld_pkg::CHAR_PLUS : mrld_pkg::CHAR_MINUS;
	assign prod    = ({{4{1'b0}}, count} << 3) + ({{4{1'b0}}, count} << 1)
	               + {{COUNT_WIDTH{1'b0}}, b[3:0]};
	assign ovf     = |prod[COUNT_WIDTH+3:COUNT_WIDTH];
	assign cnt_ext = {{mrld_pkg::REPEAT_W{1'b0}}, count};

	always_comb begin
		flags_nxt        = flags;
		count_nxt        = count;
		emit             = 1'b0;
		res.out_byte     = '0;
		res.repeat_count = '0;
		res.status       = mrld_pkg::ST_OK;
		res.done_res     = 1'b0;
		if (flags.stopped) begin
			emit = 1'b0;
		end else if (src.end_of_stream) begin
			flags_nxt.stopped = 1'b1;
			flags_nxt.in_run  = 1'b0;
			emit              = 1'b1;
			res.done_res      = 1'b1;
			res.status        = flags.in_run ? mrld_pkg::ST_UNTERMINATED : mrld_pkg::ST_OK;
		end else if (!flags.in_run) begin
			if (b == mrld_pkg::CHAR_PLUS || b == mrld_pkg::CHAR_MINUS) begin
				flags_nxt.in_run      = 1'b1;
				flags_nxt.run_is_ones = (b == mrld_pkg::CHAR_PLUS);
				flags_nxt.seen_digit  = 1'b0;
				count_nxt             = '0;
			end else begin
				emit             = 1'b1;
				res.out_byte     = b;
				res.repeat_count = {{(mrld_pkg::REPEAT_W-1){1'b0}}, 1'b1};
			end
		end else if (b == marker) begin
			emit = 1'b1;
			if (!flags.seen_digit) begin
				flags_nxt.stopped = 1'b1;
				flags_nxt.in_run  = 1'b0;
				res.done_res      = 1'b1;
				res.status        = mrld_pkg::ST_EMPTY;
			end else begin
				flags_nxt.in_run = 1'b0;
				res.out_byte     = flags.run_is_ones ? mrld_pkg::CHAR_ONE : mrld_pkg::CHAR_ZERO;
				res.repeat_count = cnt_ext[mrld_pkg::REPEAT_W-1:0];
			end
		end else if (b < mrld_pkg::CHAR_ZERO || b > mrld_pkg::CHAR_NINE) begin
			flags_nxt.stopped = 1'b1;
			flags_nxt.in_run  = 1'b0;
			emit              = 1'b1;
			res.done_res      = 1'b1;
			res.status        = mrld_pkg::ST_NONDIGIT;
		end else begin
			flags_nxt.seen_digit = 1'b1;
			if (ovf) begin
				flags_nxt.stopped = 1'b1;
				flags_nxt.in_run  = 1'b0;
				emit              = 1'b1;
				res.done_res      = 1'b1;
				res.status        = mrld_pkg::ST_OVERFLOW;
			end else begin
				count_nxt = prod[COUNT_WIDTH-1:0];
			end
		end
	end

endmodule

[rtl/marker_run_length_decoder_unit.sv]
// Top level of the marker run-length decoder: input register, step logic, result register.
//
//   channel | signals                      | payload
//   src     | src_valid, src_ready, src    | mrld_pkg::src_t (one stream byte)
//   res     | res_valid, res_ready, res    | mrld_pkg::res_t (zero or one per byte)
//
// One byte per cycle unless res stalls; a result is loaded from the input register.
// The decimal accumulate (count * 10 + digit) and its overflow check sit in one stage.
// Reset clears the run state and both valid flags; after a final result, bytes are
// still taken but give nothing until reset.
// A stalled result register holds the input register, and src_ready drops only then.
module marker_run_length_decoder_unit #(
	parameter int COUNT_WIDTH = mrld_pkg::COUNT_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	output logic           src_ready,
	input  mrld_pkg::src_t src,
	output logic           res_valid,
	input  logic           res_ready,
	output mrld_pkg::res_t res
);

	logic                   valid_s1;
	mrld_pkg::src_t         src_s1;
	logic                   res_valid_q;
	mrld_pkg::res_t         res_q;
	mrld_pkg::flags_t       flags_q;
	logic [COUNT_WIDTH-1:0] count_q;

	mrld_pkg::flags_t       flags_nxt;
	logic [COUNT_WIDTH-1:0] count_nxt;
	logic                   emit;
	mrld_pkg::res_t         step_res;
	logic                   adv_s1;

	assign adv_s1    = !res_valid_q || res_ready;
	assign src_ready = !valid_s1 || adv_s1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	mrld_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.src      (src_s1),
		.flags    (flags_q),
		.count    (count_q),
		.flags_nxt(flags_nxt),
		.count_nxt(count_nxt),
		.emit     (emit),
		.res      (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			flags_q     <= '0;
			count_q     <= '0;
		end else begin
			if (src_ready) begin
				valid_s1 <= src_valid;
			end
			if (adv_s1) begin
				res_valid_q <= valid_s1 && emit;
				if (valid_s1) begin
					flags_q <= flags_nxt;
					count_q <= count_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			src_s1 <= src;
		end
		if (adv_s1 && valid_s1 && emit) begin
			res_q <= step_res;
		end
	end

endmodule

[tb/sv/tb.sv]
// Testbench for the marker run-length decoder: queued byte stream, decode predictor, checks.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int              TARGET_BYTES = 1450;
	localparam int              STALL_LIMIT  = 4000;
	localparam int              DRAIN_CYCLES = 20;
	localparam longint unsigned COUNT_MAX    =
		(64'd1 << mrld_pkg::COUNT_WIDTH_DEF) - 64'd1;

	typedef enum int {
		END_EOS_IDLE,
		END_EOS_IN_RUN,
		END_NONDIGIT,
		END_EMPTY,
		END_OVERFLOW
	} stream_end_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           src_valid = 1'b0;
	logic           src_ready;
	mrld_pkg::src_t src = '0;
	logic           res_valid;
	logic           res_ready = 1'b0;
	mrld_pkg::res_t res;

	mrld_pkg::src_t pending_bytes[$];
	mrld_pkg::res_t expected_codes[$];
	int   stream_len = 0;
	int   bytes_sent = 0;
	int   error_count = 0;
	int   quiet_cycles = 0;

	// decoder state mirror
	bit              dec_in_run = 1'b0;
	bit              dec_ones = 1'b0;
	bit              dec_seen = 1'b0;
	bit              dec_stopped = 1'b0;
	longint unsigned dec_count = 64'd0;

	marker_run_length_decoder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src       (src),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void halt_decode(input logic [mrld_pkg::STATUS_W-1:0] code,
		output mrld_pkg::res_t r);
		r          = '0;
		r.status   = code;
		r.done_res = 1'b1;
		dec_stopped = 1'b1;
		dec_in_run  = 1'b0;
	endfunction

	function automatic bit decode_byte(input mrld_pkg::src_t s, output mrld_pkg::res_t r);
		longint unsigned digit;
		r = '0;
		if (dec_stopped)
			return 1'b0;
		if (s.end_of_stream) begin
			halt_decode(dec_in_run ? mrld_pkg::ST_UNTERMINATED : mrld_pkg::ST_OK, r);
			return 1'b1;
		end
		if (!dec_in_run) begin
			if (s.in_byte == mrld_pkg::CHAR_PLUS || s.in_byte == mrld_pkg::CHAR_MINUS) begin
				dec_in_run = 1'b1;
				dec_ones   = (s.in_byte == mrld_pkg::CHAR_PLUS);
				dec_count  = 64'd0;
				dec_seen   = 1'b0;
				return 1'b0;
			end
			r.out_byte     = s.in_byte;
			r.repeat_count = mrld_pkg::REPEAT_W'(1);
			return 1'b1;
		end
		if (s.in_byte == (dec_ones ? mrld_pkg::CHAR_PLUS : mrld_pkg::CHAR_MINUS)) begin
			if (!dec_seen) begin
				halt_decode(mrld_pkg::ST_EMPTY, r);
				return 1'b1;
			end
			dec_in_run     = 1'b0;
			r.out_byte     = dec_ones ? mrld_pkg::CHAR_ONE : mrld_pkg::CHAR_ZERO;
			r.repeat_count = dec_count[mrld_pkg::REPEAT_W-1:0];
			return 1'b1;
		end
		if (s.in_byte < mrld_pkg::CHAR_ZERO || s.in_byte > mrld_pkg::CHAR_NINE) begin
			halt_decode(mrld_pkg::ST_NONDIGIT, r);
			return 1'b1;
		end
		digit    = 64'(s.in_byte - mrld_pkg::CHAR_ZERO);
		dec_seen = 1'b1;
		if (dec_count > (COUNT_MAX - digit) / 64'd10) begin
			halt_decode(mrld_pkg::ST_OVERFLOW, r);
			return 1'b1;
		end
		dec_count = dec_count * 64'd10 + digit;
		return 1'b0;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic eos);
		mrld_pkg::src_t s;
		s.in_byte       = b;
		s.end_of_stream = eos;
		pending_bytes.push_back(s);
	endtask

	task automatic push_digits(input longint unsigned value, input int zeros);
		logic [7:0] digits[$];
		longint unsigned v;
		v = value;
		repeat (zeros)
			push_byte(mrld_pkg::CHAR_ZERO, 1'b0);
		do begin
			digits.push_front(mrld_pkg::CHAR_ZERO + 8'(v % 64'd10));
			v = v / 64'd10;
		end while (v != 64'd0);
		foreach (digits[i])
			push_byte(digits[i], 1'b0);
	endtask

	task automatic push_run(input logic [7:0] marker, input longint unsigned value,
		input int zeros);
		push_byte(marker, 1'b0);
		push_digits(value, zeros);
		push_byte(marker, 1'b0);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == mrld_pkg::CHAR_PLUS || b == mrld_pkg::CHAR_MINUS);
		return b;
	endfunction

	function automatic logic [7:0] random_marker();
		return $urandom_range(0, 1) ? mrld_pkg::CHAR_PLUS : mrld_pkg::CHAR_MINUS;
	endfunction

	function automatic longint unsigned random_count();
		case ($urandom_range(0, 4))
			0: return 64'($urandom_range(0, 9));
			1: return 64'($urandom_range(10, 9999));
			2: return COUNT_MAX - 64'($urandom_range(0, 20));
			default: return 64'($urandom());
		endcase
	endfunction

	function automatic int send_gap_pct();
		if (bytes_sent * 3 < stream_len)
			return 10;
		if (bytes_sent * 3 < stream_len * 2)
			return 87;
		return 0;
	endfunction

	function automatic int recv_stall_pct();
		if (bytes_sent * 3 < stream_len)
			return 87;
		if (bytes_sent * 3 < stream_len * 2)
			return 10;
		return 0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else if (!src_valid || src_ready) begin
			if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
				src        <= pending_bytes.pop_front();
				src_valid  <= 1'b1;
				bytes_sent <= bytes_sent + 1;
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(0, 99) >= recv_stall_pct());
		end
	end

	// monitor
	always @(posedge clk) begin
		mrld_pkg::res_t want;
		if (arst_n) begin
			if (src_valid && src_ready) begin
				if (decode_byte(src, want))
					expected_codes.push_back(want);
			end
			if (res_valid && res_ready) begin
				if (expected_codes.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected transfer: %0h/%0d/%0d/%0b",
							res.out_byte, res.repeat_count, res.status, res.done_res);
				end else begin
					want = expected_codes.pop_front();
					if (res.out_byte !== want.out_byte ||
						res.repeat_count !== want.repeat_count ||
						res.status !== want.status || res.done_res !== want.done_res) begin
						error_count++;
						if (error_count <= 10)
							$display("mismatch: exp %0h/%0d/%0d/%0b got %0h/%0d/%0d/%0b",
								want.out_byte, want.repeat_count, want.status,
								want.done_res, res.out_byte, res.repeat_count,
								res.status, res.done_res);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && src_ready) || (res_valid && res_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		stream_end_t     ending;
		longint unsigned big;
		logic [7:0]      marker;
		logic [7:0]      b;

		// directed: pass-through extremes, both run kinds, zero and full counts
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(mrld_pkg::CHAR_NINE, 1'b0);
		push_run(mrld_pkg::CHAR_PLUS, 64'd0, 0);
		push_run(mrld_pkg::CHAR_MINUS, COUNT_MAX, 0);
		push_run(mrld_pkg::CHAR_PLUS, 64'd7, 2);
		push_run(mrld_pkg::CHAR_MINUS, 64'd9, 0);
		push_byte(8'h80, 1'b0);

		while (pending_bytes.size() < TARGET_BYTES) begin
			if ($urandom_range(0, 99) < 60)
				push_byte(plain_byte(), 1'b0);
			else
				push_run(random_marker(), random_count(),
					($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 3)) : 0);
		end

		// terminating sequence, one per run since only reset clears a stop
		ending = stream_end_t'($urandom_range(0, 4));
		marker = random_marker();
		case (ending)
			END_EOS_IDLE: push_byte(8'($urandom_range(0, 255)), 1'b1);
			END_EOS_IN_RUN: begin
				push_byte(marker, 1'b0);
				if ($urandom_range(0, 1))
					push_digits(64'($urandom_range(0, 999)), 0);
				push_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			END_NONDIGIT: begin
				push_byte(marker, 1'b0);
				if ($urandom_range(0, 1))
					push_digits(64'($urandom_range(0, 999)), 0);
				if ($urandom_range(0, 1)) begin
					push_byte((marker == mrld_pkg::CHAR_PLUS) ?
						mrld_pkg::CHAR_MINUS : mrld_pkg::CHAR_PLUS, 1'b0);
				end else begin
					do
						b = 8'($urandom_range(0, 255));
					while (b == marker ||
						(b >= mrld_pkg::CHAR_ZERO && b <= mrld_pkg::CHAR_NINE));
					push_byte(b, 1'b0);
				end
			end
			END_EMPTY: begin
				push_byte(marker, 1'b0);
				push_byte(marker, 1'b0);
			end
			default: begin
				big = COUNT_MAX + 64'd1 +
					(64'($urandom()) % (64'd9999999999 - COUNT_MAX));
				push_run(marker, big, int'($urandom_range(0, 2)));
			end
		endcase
		// block is stopped now; these bytes must give nothing
		repeat (8)
			push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

		stream_len = pending_bytes.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || src_valid)
			@(posedge clk);
		while (expected_codes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_codes.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
